// ===== rtl/core/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types, sizes and helpers for the sliding window maximum unit.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int WINDOW_MAX  = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int POS_W       = 16;
	localparam int WLEN_W      = 11;
	localparam int PTR_W       = $clog2(WINDOW_MAX);
	localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W       = (SAMPLE_BITS > POS_W) ? SAMPLE_BITS : POS_W;

	typedef logic [PTR_W-1:0]       ptr_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [POS_W-1:0]       pos_t;
	typedef logic [SAMPLE_BITS-1:0] smp_t;
	typedef logic [CMP_W-1:0]       cmp_t;

	typedef struct packed {
		smp_t value;
		pos_t pos;
	} entry_t;

	typedef struct packed {
		logic   we;
		ptr_t   waddr;
		entry_t wdata;
		ptr_t   raddr;
	} ram_req_t;

	function automatic ptr_t next_slot(input ptr_t p);
		next_slot = (p == ptr_t'(WINDOW_MAX - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	function automatic ptr_t prev_slot(input ptr_t p);
		prev_slot = (p == '0) ? ptr_t'(WINDOW_MAX - 1) : p - ptr_t'(1);
	endfunction

	// signed value to order-preserving unsigned key
	function automatic smp_t order_key(input smp_t v);
		order_key = v ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	endfunction

endpackage

// ===== rtl/core/swm_deque_ram.sv =====
// ----------------------------------------------------------------------------
// swm_deque_ram
// Circular deque store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swm_deque_ram (
	input  logic              clk,
	input  swm_pkg::ram_req_t req,
	output swm_pkg::entry_t   rd_data
);

	swm_pkg::entry_t mem_q [swm_pkg::WINDOW_MAX];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_data <= mem_q[req.raddr];
	end

endmodule

// ===== rtl/core/swm_cmp.sv =====
// ----------------------------------------------------------------------------
// swm_cmp
// Shared unsigned magnitude compare, used for both age and value checks.
// ----------------------------------------------------------------------------
module swm_cmp (
	input  swm_pkg::cmp_t op_a,
	input  swm_pkg::cmp_t op_b,
	output logic          a_ge_b
);

	logic [swm_pkg::CMP_W:0] diff;

	assign diff   = {1'b0, op_a} - {1'b0, op_b};
	assign a_ge_b = ~diff[swm_pkg::CMP_W];

endmodule

// ===== rtl/core/swm_seq.sv =====
// ----------------------------------------------------------------------------
// swm_seq
// Sequencer: drops aged front entries, pops smaller back entries, appends the
// sample and produces the window maximum through one shared comparator.
// ----------------------------------------------------------------------------
module swm_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  swm_pkg::smp_t              sample,
	input  logic                       start_req,
	input  logic [swm_pkg::WLEN_W-1:0] window_length,
	output logic                       out_valid,
	input  logic                       out_stall,
	output swm_pkg::smp_t              window_max,
	output swm_pkg::ram_req_t          ram_req,
	input  swm_pkg::entry_t            rd_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DROP,
		ST_POP
	} state_t;

	state_t        state_q;
	swm_pkg::ptr_t head_q;
	swm_pkg::ptr_t tail_q;
	swm_pkg::cnt_t count_q;
	swm_pkg::pos_t pos_q;
	logic          filled_q;
	swm_pkg::smp_t smp_q;
	swm_pkg::pos_t win_q;
	swm_pkg::smp_t front_q;
	logic          out_valid_q;
	swm_pkg::smp_t window_max_q;

	logic          accept;
	logic          hit;
	swm_pkg::cmp_t op_a;
	swm_pkg::cmp_t op_b;
	swm_pkg::pos_t age;
	swm_pkg::pos_t win_clamp;
	logic          fill_now;
	logic          can_push;
	swm_pkg::smp_t front_val;

	assign in_stall   = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign window_max = window_max_q;

	always_comb begin
		if (window_length == '0) begin
			win_clamp = swm_pkg::pos_t'(1);
		end else if (swm_pkg::pos_t'(window_length) > swm_pkg::pos_t'(swm_pkg::WINDOW_MAX)) begin
			win_clamp = swm_pkg::pos_t'(swm_pkg::WINDOW_MAX);
		end else begin
			win_clamp = swm_pkg::pos_t'(window_length);
		end
	end

	assign age = pos_q - rd_data.pos;

	// drop: age >= window; pop: key(sample) >= key(back value)
	always_comb begin
		if (state_q == ST_DROP) begin
			op_a = swm_pkg::cmp_t'(age);
			op_b = swm_pkg::cmp_t'(win_q);
		end else begin
			op_a = swm_pkg::cmp_t'(swm_pkg::order_key(smp_q));
			op_b = swm_pkg::cmp_t'(swm_pkg::order_key(rd_data.value));
		end
	end

	swm_cmp u_cmp (
		.op_a   (op_a),
		.op_b   (op_b),
		.a_ge_b (hit)
	);

	assign fill_now  = ({1'b0, pos_q} + {{swm_pkg::POS_W{1'b0}}, 1'b1}) >= {1'b0, win_q};
	assign can_push  = count_q < swm_pkg::cnt_t'(swm_pkg::WINDOW_MAX);
	// front is the new sample when the deque ran empty
	assign front_val = (count_q == '0) ? smp_q : front_q;

	always_comb begin
		ram_req.we          = 1'b0;
		ram_req.waddr       = tail_q;
		ram_req.wdata.value = smp_q;
		ram_req.wdata.pos   = pos_q;
		ram_req.raddr       = head_q;
		case (state_q)
			ST_IDLE: begin
				ram_req.raddr = head_q;
			end
			ST_DROP: begin
				if (count_q != '0 && hit) begin
					ram_req.raddr = swm_pkg::next_slot(head_q);
				end else begin
					ram_req.raddr = swm_pkg::prev_slot(tail_q);
				end
			end
			ST_POP: begin
				ram_req.raddr = swm_pkg::prev_slot(swm_pkg::prev_slot(tail_q));
				if (!(count_q != '0 && hit)) begin
					ram_req.we = can_push;
				end
			end
			default: begin
				ram_req.raddr = head_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			filled_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						smp_q   <= sample;
						win_q   <= win_clamp;
						state_q <= ST_DROP;
						if (start_req) begin
							head_q   <= '0;
							tail_q   <= '0;
							count_q  <= '0;
							pos_q    <= '0;
							filled_q <= 1'b0;
						end
					end
				end
				ST_DROP: begin
					if (count_q != '0 && hit) begin
						head_q  <= swm_pkg::next_slot(head_q);
						count_q <= count_q - swm_pkg::cnt_t'(1);
					end else begin
						front_q <= rd_data.value;
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					if (count_q != '0 && hit) begin
						tail_q  <= swm_pkg::prev_slot(tail_q);
						count_q <= count_q - swm_pkg::cnt_t'(1);
					end else begin
						if (can_push) begin
							tail_q  <= swm_pkg::next_slot(tail_q);
							count_q <= count_q + swm_pkg::cnt_t'(1);
						end
						pos_q <= pos_q + swm_pkg::pos_t'(1);
						if (filled_q || fill_now) begin
							filled_q     <= 1'b1;
							out_valid_q  <= 1'b1;
							window_max_q <= front_val;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/sliding_window_maximum_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum_unit
// Streaming maximum over the most recent window_length samples.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with sample and start_req. A transaction
// with start_req set clears the deque and begins a new stream with its sample.
// Output channel: out_valid / out_stall with window_max. Once a stream holds
// window_length samples, each input transaction gives one output transaction;
// before that it gives none.
// window_length is to be written through cfg_wen / cfg_wdata only while the
// unit is idle; the unit itself does not enforce this. Zero acts as one,
// values above 1024 act as 1024. From acceptance, each sample steps through
// ST_DROP, one step per aged front entry dropped plus a final check, then
// ST_POP, one step per back entry popped plus the append; no new sample is
// taken until the unit is back in ST_IDLE. Every step goes through the single
// read port of the deque memory and the one shared comparator. Each sample
// leaves the deque at most once.
// Reset clears the pointers, count, position and window fill flag and sets
// window_length to 3; the deque memory is not cleared. While out_stall holds
// a result, the unit accepts no new sample.
// ----------------------------------------------------------------------------
module sliding_window_maximum_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [swm_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                             start_req,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [swm_pkg::SAMPLE_BITS-1:0] window_max,
	input  logic                             cfg_wen,
	input  logic [swm_pkg::WLEN_W-1:0]       cfg_wdata
);

	logic [swm_pkg::WLEN_W-1:0] window_length_q;
	swm_pkg::ram_req_t          ram_req;
	swm_pkg::entry_t            rd_data;
	swm_pkg::smp_t              max_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= swm_pkg::WLEN_W'(3);
		end else if (cfg_wen) begin
			window_length_q <= cfg_wdata;
		end
	end

	swm_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample        (swm_pkg::smp_t'(sample)),
		.start_req     (start_req),
		.window_length (window_length_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.window_max    (max_raw),
		.ram_req       (ram_req),
		.rd_data       (rd_data)
	);

	swm_deque_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	assign window_max = $signed(max_raw);

endmodule

// ===== rtl/core/swm_checker.sv =====
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks for the sliding window maximum unit, bound to the top.
// ----------------------------------------------------------------------------
module swm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [swm_pkg::SAMPLE_BITS-1:0] window_max
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(window_max))
		else $error("stalled result changed");

	// busy right after taking a sample
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted back to back");

	// no new sample while a result is blocked
	a_no_accept_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output blocked");

	// a result only follows a busy cycle
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without processing");

endmodule

bind sliding_window_maximum_unit swm_checker u_swm_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window maximum unit: a directed table of
// corner cases, then random sample streams under several idle and stall
// patterns. Predicted rows are checked against an in-bench deque model.
// ----------------------------------------------------------------------------
module tb;

	localparam int DRAIN_CYCLES = 2 * swm_pkg::WINDOW_MAX + 16;
	localparam int HOLD_CYCLES  = 800;
	localparam int QUIET_LIMIT  = 12000;
	localparam int N_PHASES     = 9;
	localparam int PHASE_ITEMS  = 103;
	localparam int EXP_DEPTH    = 16;

	typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_NONE, ROW_VAL} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic       start;
		logic [15:0] value;
		logic [15:0] want;
	} row_t;

	// value is the sample, or the window length on a register row
	row_t dir_rows [25] = '{
		'{ROW_NONE, 1'b0, 16'h0005, 16'h0000},
		'{ROW_NONE, 1'b0, 16'hFFF9, 16'h0000},
		'{ROW_VAL,  1'b0, 16'h0003, 16'h0005},
		'{ROW_VAL,  1'b0, 16'h7FFF, 16'h7FFF},
		'{ROW_VAL,  1'b0, 16'h8000, 16'h7FFF},
		'{ROW_VAL,  1'b0, 16'h8000, 16'h7FFF},
		'{ROW_VAL,  1'b0, 16'h8000, 16'h8000},
		'{ROW_CFG,  1'b0, 16'd1,    16'h0000},
		'{ROW_VAL,  1'b1, 16'h8000, 16'h8000},
		'{ROW_VAL,  1'b0, 16'h7FFF, 16'h7FFF},
		'{ROW_VAL,  1'b0, 16'h0000, 16'h0000},
		'{ROW_CFG,  1'b0, 16'd0,    16'h0000},
		'{ROW_VAL,  1'b0, 16'hFFFF, 16'hFFFF},
		'{ROW_VAL,  1'b0, 16'h3039, 16'h3039},
		'{ROW_CFG,  1'b0, 16'd2047, 16'h0000},
		'{ROW_NONE, 1'b1, 16'h0064, 16'h0000},
		'{ROW_NONE, 1'b0, 16'h00C8, 16'h0000},
		'{ROW_CFG,  1'b0, 16'd2,    16'h0000},
		'{ROW_PRED, 1'b0, 16'h0032, 16'h0000},
		'{ROW_CFG,  1'b0, 16'd6,    16'h0000},
		'{ROW_PRED, 1'b0, 16'h000A, 16'h0000},
		'{ROW_PRED, 1'b0, 16'h012C, 16'h0000},
		'{ROW_PRED, 1'b1, 16'h0007, 16'h0000},
		'{ROW_PRED, 1'b0, 16'h0007, 16'h0000},
		'{ROW_PRED, 1'b0, 16'hFFFF, 16'h0000}
	};

	int phase_win [N_PHASES] = '{4, 1, 1024, 2047, 2, 0, 9, 33, 3};
	int phase_snd [N_PHASES] = '{0, 59, 0, 19, 0, 59, 0, 19, 0};
	int phase_rx  [N_PHASES] = '{0, 0, 59, 19, 0, 0, 59, 19, 0};

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  in_valid = 1'b0;
	logic                                  in_stall;
	logic signed [swm_pkg::SAMPLE_BITS-1:0] sample = '0;
	logic                                  start_req = 1'b0;
	logic                                  out_valid;
	logic                                  out_stall = 1'b0;
	logic signed [swm_pkg::SAMPLE_BITS-1:0] window_max;
	logic                                  cfg_wen = 1'b0;
	logic [swm_pkg::WLEN_W-1:0]            cfg_wdata = '0;

	sliding_window_maximum_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.start_req (start_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.window_max(window_max),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// deque model state
	swm_pkg::smp_t              dq_val [swm_pkg::WINDOW_MAX];
	swm_pkg::pos_t              dq_pos [swm_pkg::WINDOW_MAX];
	int unsigned                dq_head = 0;
	int unsigned                dq_tail = 0;
	int unsigned                dq_cnt = 0;
	swm_pkg::pos_t              next_pos = '0;
	bit                         filled = 1'b0;
	logic [swm_pkg::WLEN_W-1:0] win_reg = swm_pkg::WLEN_W'(3);

	// expected results in order: written by the sender, read by the monitor
	swm_pkg::smp_t exp_mem [EXP_DEPTH];
	int            exp_wr = 0;
	int            exp_rd = 0;

	int            mismatches = 0;
	int            snd_pct = 0;
	int            rx_pct = 0;
	int            hold_asked = 0;
	int            hold_served = 0;
	int            hold_left = 0;
	int            quiet = 0;
	swm_pkg::smp_t want_max;

	// Returns 1 when the sample yields a maximum, written to m.
	function automatic bit slide_window_max(input swm_pkg::smp_t s, input logic st,
		output swm_pkg::smp_t m);
		int unsigned w;
		int unsigned last;
		swm_pkg::pos_t p;
		swm_pkg::pos_t age;
		w = (win_reg == '0) ? 1 : int'(win_reg);
		if (w > swm_pkg::WINDOW_MAX)
			w = swm_pkg::WINDOW_MAX;
		if (st) begin
			dq_head  = 0;
			dq_tail  = 0;
			dq_cnt   = 0;
			next_pos = '0;
			filled   = 1'b0;
		end
		p = next_pos;
		// drop aged front entries; age is modulo the position width
		while (dq_cnt > 0) begin
			age = p - dq_pos[dq_head];
			if (age < w)
				break;
			dq_head = (dq_head + 1) % swm_pkg::WINDOW_MAX;
			dq_cnt--;
		end
		// pop back entries not above the sample, newest of equals survives
		while (dq_cnt > 0) begin
			last = (dq_tail + swm_pkg::WINDOW_MAX - 1) % swm_pkg::WINDOW_MAX;
			if ($signed(dq_val[last]) > $signed(s))
				break;
			dq_tail = last;
			dq_cnt--;
		end
		if (dq_cnt < swm_pkg::WINDOW_MAX) begin
			dq_val[dq_tail] = s;
			dq_pos[dq_tail] = p;
			dq_tail = (dq_tail + 1) % swm_pkg::WINDOW_MAX;
			dq_cnt++;
		end
		if (32'(p) + 1 >= w)
			filled = 1'b1;
		next_pos = p + swm_pkg::pos_t'(1);
		m = dq_val[dq_head];
		return filled;
	endfunction

	task automatic expect_put(input swm_pkg::smp_t v);
		exp_mem[exp_wr % EXP_DEPTH] = v;
		exp_wr++;
	endtask

	task automatic offer(input swm_pkg::smp_t s, input logic st, input row_kind_t kind,
		input swm_pkg::smp_t want);
		swm_pkg::smp_t m;
		bit            got;
		@(negedge clk);
		while ($urandom_range(99, 0) < snd_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		sample    <= s;
		start_req <= st;
		do @(posedge clk); while (in_stall);
		got = slide_window_max(s, st, m);
		case (kind)
			ROW_NONE: ;
			ROW_VAL: expect_put(want);
			default: if (got) expect_put(m);
		endcase
	endtask

	// bring the unit to idle: no transaction offered, all results in, pipe empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input logic [swm_pkg::WLEN_W-1:0] len);
		settle();
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= len;
		win_reg = len;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic stream_burst(input int n, input bit allow_start);
		int            left;
		int            seg;
		int            shape;
		int            step;
		swm_pkg::smp_t v;
		left = n;
		while (left > 0) begin
			seg   = $urandom_range(40, 1);
			shape = $urandom_range(5, 0);
			step  = $urandom_range(300, 1);
			v     = swm_pkg::smp_t'($urandom);
			for (int k = 0; k < seg && left > 0; k++) begin
				case (shape)
					0: v = swm_pkg::smp_t'($urandom);
					1: v = v + swm_pkg::smp_t'(step);
					2: v = v - swm_pkg::smp_t'(step);
					3: ;
					4: v = $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
					default: v = swm_pkg::smp_t'($urandom_range(8, 0) - 4);
				endcase
				offer(v, allow_start && ($urandom_range(59, 0) == 0), ROW_PRED, '0);
				left--;
			end
		end
	endtask

	// receiver: random stalls, or a long hold-off when one is asked for
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_CYCLES;
			out_stall   <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99, 0) < rx_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (exp_wr == exp_rd) begin
				mismatches++;
				$display("%0t: unexpected window_max %0d, none expected", $time,
					$signed(window_max));
			end else begin
				want_max = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (window_max !== want_max) begin
					mismatches++;
					$display("%0t: window_max mismatch: expected %0d, got %0d", $time,
						$signed(want_max), $signed(window_max));
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				set_window(dir_rows[i].value[swm_pkg::WLEN_W-1:0]);
			else
				offer(dir_rows[i].value, dir_rows[i].start, dir_rows[i].kind,
					dir_rows[i].want);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			set_window(swm_pkg::WLEN_W'(phase_win[p]));
			snd_pct = phase_snd[p];
			rx_pct  = phase_rx[p];
			if (p == 4)
				hold_asked++;
			// a restart under a wide window would starve the output
			stream_burst(PHASE_ITEMS, phase_win[p] <= 64);
		end

		settle();
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
